@@ rtl/hpq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the max-heap priority queue.
package hpq_pkg;

  localparam int DEF_DEPTH    = 64;
  localparam int DEF_KEY_BITS = 16;
  localparam int DEF_TAG_BITS = 16;

  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int CAP_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    SEL_SELF,
    SEL_LEFT,
    SEL_RIGHT
  } sel_t;

endpackage

@@ rtl/hpq_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hpq_pick.sv @@
`timescale 1ns / 1ps
// Sift-down step: picks which of parent, left or right child holds the largest key.
module hpq_pick #(
  parameter int KEY_BITS = hpq_pkg::DEF_KEY_BITS
) (
  input  logic [KEY_BITS-1:0] mv_key,
  input  logic [KEY_BITS-1:0] l_key,
  input  logic [KEY_BITS-1:0] r_key,
  input  logic                l_ok,
  input  logic                r_ok,
  output hpq_pkg::sel_t       sel
);
  import hpq_pkg::*;

  logic [KEY_BITS-1:0] big_key;

  // strict compares: on equal keys the left child (or the parent) stays
  always_comb begin
    sel     = SEL_SELF;
    big_key = mv_key;
    if (l_ok && (l_key > mv_key)) begin
      sel     = SEL_LEFT;
      big_key = l_key;
    end
    if (r_ok && (r_key > big_key)) begin
      sel = SEL_RIGHT;
    end
  end

endmodule

@@ rtl/max_heap_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// Top level of the binary max-heap priority queue.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+----------------------------
//  command   | start, busy, operation, key, tag         | taken when start && !busy
//  result    | done, status, out_key, out_tag, count    | one-cycle strobe on done
//  config    | cfg_valid, cfg_ready, cfg_capacity       | written when valid && ready
//
// One request at a time. Refused, empty and unused-code requests strobe done in the cycle
// after acceptance; peek passes through S_ROOT, insert into a non-empty heap walks up
// through S_UP (and S_FIN at the root), pop passes S_ROOT and walks down through S_DOWN.
// Each heap level takes one read of the mirrored RAM pair, one compare, one write back.
// Reset clears the count; the heap RAM is not cleared. The result side cannot stall.
module max_heap_priority_queue_unit #(
  parameter int DEPTH    = hpq_pkg::DEF_DEPTH,
  parameter int KEY_BITS = hpq_pkg::DEF_KEY_BITS,
  parameter int TAG_BITS = hpq_pkg::DEF_TAG_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [hpq_pkg::OP_W-1:0]    operation,
  input  logic [KEY_BITS-1:0]         key,
  input  logic [TAG_BITS-1:0]         tag,
  output logic                        done,
  output logic [hpq_pkg::ST_W-1:0]    status,
  output logic [KEY_BITS-1:0]         out_key,
  output logic [TAG_BITS-1:0]         out_tag,
  output logic [$clog2(DEPTH+1)-1:0]  count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hpq_pkg::CAP_W-1:0]   cfg_capacity
);
  import hpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int WW = KEY_BITS + TAG_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;

  logic [2:0]          state;
  logic [CAP_W-1:0]    capacity;
  logic                is_pop;
  logic [KEY_BITS-1:0] mv_key;
  logic [TAG_BITS-1:0] mv_tag;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       pidx;
  logic                done_next;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [WW-1:0] rdata_a;
  logic [WW-1:0] rdata_b;

  logic [KEY_BITS-1:0] a_key;
  logic [TAG_BITS-1:0] a_tag;
  logic [KEY_BITS-1:0] b_key;
  logic [TAG_BITS-1:0] b_tag;

  logic          full;
  logic [AW-1:0] cnt_a;
  logic [AW-1:0] cnt_parent;
  logic [AW-1:0] last;
  logic [AW-1:0] pidx_parent;
  logic          up_swap;
  logic [IW-1:0] l_idx;
  logic [IW-1:0] r_idx;
  logic          l_ok;
  logic          r_ok;
  sel_t          sel;
  logic [AW-1:0] child;
  logic [IW-1:0] cl_idx;
  logic [IW-1:0] cr_idx;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign a_key = rdata_a[WW-1:TAG_BITS];
  assign a_tag = rdata_a[TAG_BITS-1:0];
  assign b_key = rdata_b[WW-1:TAG_BITS];
  assign b_tag = rdata_b[TAG_BITS-1:0];

  // capacity above DEPTH saturates, so the count reaching DEPTH is full as well
  assign full = (EW'(count) >= EW'(capacity)) || (count == CW'(DEPTH));

  assign cnt_a       = count[AW-1:0];
  assign cnt_parent  = AW'(cnt_a - AW'(1)) >> 1;
  assign last        = AW'(count - CW'(1));
  assign pidx_parent = AW'(pidx - AW'(1)) >> 1;
  assign up_swap     = (a_key < mv_key);

  assign l_idx  = {1'b0, idx, 1'b1};
  assign r_idx  = IW'(l_idx + IW'(1));
  assign l_ok   = (l_idx < IW'(count));
  assign r_ok   = (r_idx < IW'(count));
  assign child  = (sel == SEL_LEFT) ? l_idx[AW-1:0] : r_idx[AW-1:0];
  assign cl_idx = {1'b0, child, 1'b1};
  assign cr_idx = IW'(cl_idx + IW'(1));

  hpq_pick #(
    .KEY_BITS (KEY_BITS)
  ) u_pick (
    .mv_key (mv_key),
    .l_key  (a_key),
    .r_key  (b_key),
    .l_ok   (l_ok),
    .r_ok   (r_ok),
    .sel    (sel)
  );

  // Two mirrored copies give two read ports for the child pair.
  hpq_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  hpq_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_comb begin
    we        = 1'b0;
    waddr     = idx;
    wdata     = {mv_key, mv_tag};
    raddr_a   = '0;
    raddr_b   = '0;
    done_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_INSERT) begin
            waddr     = '0;
            wdata     = {key, tag};
            we        = !full && (count == '0);
            raddr_a   = cnt_parent;
            done_next = full || (count == '0);
          end else begin
            raddr_b   = last;
            done_next = (count == '0) ||
                        ((operation != OP_POP) && (operation != OP_PEEK));
          end
        end
      end
      S_UP: begin
        we        = 1'b1;
        done_next = !up_swap;
        if (up_swap) begin
          wdata   = rdata_a;
          raddr_a = pidx_parent;
        end
      end
      S_FIN: begin
        we        = 1'b1;
        done_next = 1'b1;
      end
      S_ROOT: begin
        raddr_a   = l_idx[AW-1:0];
        raddr_b   = r_idx[AW-1:0];
        done_next = !is_pop || (count == CW'(1));
      end
      S_DOWN: begin
        we        = 1'b1;
        done_next = (sel == SEL_SELF);
        case (sel)
          SEL_LEFT:  wdata = rdata_a;
          SEL_RIGHT: wdata = rdata_b;
          default:   wdata = {mv_key, mv_tag};
        endcase
        raddr_a = cl_idx[AW-1:0];
        raddr_b = cr_idx[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      capacity <= CAP_RESET;
      done     <= 1'b0;
    end else begin
      done <= done_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_capacity;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            out_key <= '0;
            out_tag <= '0;
            is_pop  <= (operation == OP_POP);
            mv_key  <= key;
            mv_tag  <= tag;
            if (operation == OP_INSERT) begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
                count  <= CW'(count + CW'(1));
                if (count != '0) begin
                  idx   <= cnt_a;
                  pidx  <= cnt_parent;
                  state <= S_UP;
                end
              end
            end else if ((operation == OP_POP) || (operation == OP_PEEK)) begin
              if (count == '0) begin
                status <= ST_EMPTY;
              end else begin
                status <= ST_OK;
                idx    <= '0;
                state  <= S_ROOT;
              end
            end else begin
              status <= ST_OK;
            end
          end
        end
        S_UP: begin
          if (up_swap) begin
            idx  <= pidx;
            pidx <= pidx_parent;
            if (pidx == '0) begin
              state <= S_FIN;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        S_ROOT: begin
          // RAM A holds the root, RAM B the last entry
          out_key <= a_key;
          out_tag <= a_tag;
          if (!is_pop || (count == CW'(1))) begin
            if (is_pop) begin
              count <= '0;
            end
            state <= S_IDLE;
          end else begin
            count  <= CW'(count - CW'(1));
            mv_key <= b_key;
            mv_tag <= b_tag;
            idx    <= '0;
            state  <= S_DOWN;
          end
        end
        S_DOWN: begin
          if (sel == SEL_SELF) begin
            state <= S_IDLE;
          end else begin
            idx <= child;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
